// ===== rtl/tst_pkg.sv =====
`default_nettype none
package tst_pkg;

   localparam int TOUCH_SLOTS      = 10;
   localparam int POINTS_PER_FRAME = 4;
   localparam int MAX_POINTS       = 4;
   localparam int SLOT_IW          = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;
   localparam int COORD_W          = 16;
   localparam int DIST_W           = 34;
   localparam int TRAVEL_W         = 17;
   localparam int HOLD_W           = 8;
   localparam int SQRT_STEPS       = DIST_W / 2;
   localparam int SQRT_CW          = $clog2(SQRT_STEPS + 1);

   localparam logic [33:0] MATCH_RESET = 34'd2500;
   localparam logic [33:0] STILL_RESET = 34'd100;
   localparam logic [7:0]  HOLD_RESET  = 8'd75;

   typedef enum logic [1:0] {
      CSR_MATCH = 2'd0,
      CSR_STILL = 2'd1,
      CSR_HOLD  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_BEGAN = 3'd1,
      PH_MOVED = 3'd2,
      PH_STILL = 3'd3,
      PH_ENDED = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      DSEL_POS  = 2'd0,
      DSEL_WAY  = 2'd1,
      DSEL_ORIG = 2'd2
   } dsel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_DIST,
      OP_SET_ENDED,
      OP_CLEAR,
      OP_CLAIM_POS,
      OP_MOVED_WAY,
      OP_MOVED_HOLD,
      OP_STILL,
      OP_SQRT_START,
      OP_TRAVEL_WR,
      OP_BEGIN,
      OP_LOAD_RSP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [SLOT_IW-1:0] slot;
      logic [1:0]         pnt;
      dsel_type           dsel;
      logic               last;
   } cmd_type;

   typedef struct packed {
      phase_type             phase;
      logic                  lt_match;
      logic                  gt_still;
      logic                  hold_nz;
      logic                  sqrt_done;
      logic [MAX_POINTS-1:0] pt_nz;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/tst_ctrl.sv =====
`default_nettype none
module tst_ctrl
   import tst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_SLOT, ST_MSEL, ST_DW1, ST_DW2, ST_MCMP, ST_WSTART,
      ST_WCMP, ST_OSTART, ST_SQSTART, ST_SQRT, ST_NEW, ST_EMIT, ST_OUT
   } state_type;

   localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(TOUCH_SLOTS - 1);
   localparam logic [1:0]         LAST_PNT  = 2'(POINTS_PER_FRAME - 1);

   state_type                state_ff, state_in, ret_ff, ret_in;
   logic [SLOT_IW-1:0]       slot_ff, slot_in;
   logic [1:0]               pnt_ff, pnt_in;
   logic [MAX_POINTS-1:0]    avail_ff, avail_in;
   logic [TOUCH_SLOTS-1:0]   done_ff, done_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MAX_POINTS-1:0]    ppf_mask;
   logic [1:0]               first_pnt;
   logic                     any_avail;

   always_comb begin
      for (int i = 0; i < MAX_POINTS; i++) begin
         ppf_mask[i] = (i < POINTS_PER_FRAME);
      end
   end

   always_comb begin
      first_pnt = 2'd0;
      any_avail = 1'b0;
      for (int i = MAX_POINTS - 1; i >= 0; i--) begin
         if (avail_ff[i]) begin
            first_pnt = 2'(i);
            any_avail = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         slot_ff      <= '0;
         pnt_ff       <= '0;
         avail_ff     <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         slot_ff      <= slot_in;
         pnt_ff       <= pnt_in;
         avail_ff     <= avail_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      slot_in      = slot_ff;
      pnt_in       = pnt_ff;
      avail_in     = avail_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op       = OP_NONE;
      cmd.slot     = slot_ff;
      cmd.pnt      = pnt_ff;
      cmd.dsel     = DSEL_POS;
      cmd.last     = 1'b0;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            avail_in = status.pt_nz & ppf_mask;
            done_in  = '0;
            slot_in  = '0;
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            case (status.phase)
               PH_BEGAN, PH_MOVED, PH_STILL: begin
                  cmd.op   = OP_SET_ENDED;
                  pnt_in   = '0;
                  state_in = ST_MSEL;
               end
               PH_ENDED: begin
                  cmd.op           = OP_CLEAR;
                  done_in[slot_ff] = 1'b1;
                  state_in         = ST_NEW;
               end
               default: state_in = ST_NEW;
            endcase
            if (status.phase inside {PH_IDLE, PH_ENDED}) begin
               if (slot_ff == LAST_SLOT) begin
                  slot_in = '0;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_SLOT;
               end
            end
         end
         ST_MSEL, ST_MCMP: begin
            if (state_ff == ST_MSEL && avail_ff[pnt_ff]) begin
               cmd.op   = OP_DIST;
               cmd.dsel = DSEL_POS;
               ret_in   = ST_MCMP;
               state_in = ST_DW1;
            end else if (state_ff == ST_MCMP && status.lt_match) begin
               cmd.op           = OP_CLAIM_POS;
               avail_in[pnt_ff] = 1'b0;
               done_in[slot_ff] = 1'b1;
               state_in         = ST_WSTART;
            end else if (pnt_ff == LAST_PNT) begin
               if (slot_ff == LAST_SLOT) begin
                  slot_in  = '0;
                  state_in = ST_NEW;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_SLOT;
               end
            end else begin
               pnt_in   = pnt_ff + 1'b1;
               state_in = ST_MSEL;
            end
         end
         ST_DW1: state_in = ST_DW2;
         ST_DW2: state_in = ret_ff;
         ST_WSTART: begin
            cmd.op   = OP_DIST;
            cmd.dsel = DSEL_WAY;
            ret_in   = ST_WCMP;
            state_in = ST_DW1;
         end
         ST_WCMP: begin
            if (status.gt_still) begin
               cmd.op   = OP_MOVED_WAY;
               state_in = ST_OSTART;
            end else if (status.hold_nz) begin
               cmd.op   = OP_MOVED_HOLD;
               state_in = ST_OSTART;
            end else begin
               cmd.op = OP_STILL;
               if (slot_ff == LAST_SLOT) begin
                  slot_in  = '0;
                  state_in = ST_NEW;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_SLOT;
               end
            end
         end
         ST_OSTART: begin
            cmd.op   = OP_DIST;
            cmd.dsel = DSEL_ORIG;
            ret_in   = ST_SQSTART;
            state_in = ST_DW1;
         end
         ST_SQSTART: begin
            cmd.op   = OP_SQRT_START;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               cmd.op = OP_TRAVEL_WR;
               if (slot_ff == LAST_SLOT) begin
                  slot_in  = '0;
                  state_in = ST_NEW;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_SLOT;
               end
            end
         end
         ST_NEW: begin
            if (!done_ff[slot_ff] && any_avail) begin
               cmd.op              = OP_BEGIN;
               cmd.pnt             = first_pnt;
               avail_in[first_pnt] = 1'b0;
            end
            if (slot_ff == LAST_SLOT) begin
               slot_in  = '0;
               state_in = ST_EMIT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.op       = OP_LOAD_RSP;
            cmd.last     = (slot_ff == LAST_SLOT);
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (slot_ff == LAST_SLOT) begin
                  rsp_valid_in = 1'b0;
                  slot_in      = '0;
                  state_in     = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  cmd.op   = OP_LOAD_RSP;
                  cmd.slot = slot_ff + 1'b1;
                  cmd.last = ((slot_ff + 1'b1) == LAST_SLOT);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/tst_dp.sv =====
`default_nettype none
module tst_dp
   import tst_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire logic                       csr_we,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [DIST_W-1:0]          csr_wdata,
   input  wire logic signed [COORD_W-1:0]  req_p0_x,
   input  wire logic signed [COORD_W-1:0]  req_p0_y,
   input  wire logic signed [COORD_W-1:0]  req_p1_x,
   input  wire logic signed [COORD_W-1:0]  req_p1_y,
   input  wire logic signed [COORD_W-1:0]  req_p2_x,
   input  wire logic signed [COORD_W-1:0]  req_p2_y,
   input  wire logic signed [COORD_W-1:0]  req_p3_x,
   input  wire logic signed [COORD_W-1:0]  req_p3_y,
   output logic [5:0]                      rsp_slot,
   output logic [2:0]                      rsp_phase,
   output logic signed [COORD_W-1:0]       rsp_pos_x,
   output logic signed [COORD_W-1:0]       rsp_pos_y,
   output logic [TRAVEL_W-1:0]             rsp_travel,
   output logic                            rsp_last
);

   logic [DIST_W-1:0]   match_ff, still_ff;
   logic [HOLD_W-1:0]   hold_cfg_ff;

   logic signed [COORD_W-1:0] pt_x_ff [MAX_POINTS];
   logic signed [COORD_W-1:0] pt_y_ff [MAX_POINTS];

   phase_type                 phase_ff  [TOUCH_SLOTS];
   logic signed [COORD_W-1:0] pos_x_ff  [TOUCH_SLOTS];
   logic signed [COORD_W-1:0] pos_y_ff  [TOUCH_SLOTS];
   logic signed [COORD_W-1:0] org_x_ff  [TOUCH_SLOTS];
   logic signed [COORD_W-1:0] org_y_ff  [TOUCH_SLOTS];
   logic signed [COORD_W-1:0] way_x_ff  [TOUCH_SLOTS];
   logic signed [COORD_W-1:0] way_y_ff  [TOUCH_SLOTS];
   logic [TRAVEL_W-1:0]       trav_ff   [TOUCH_SLOTS];
   logic [HOLD_W-1:0]         hold_ff   [TOUCH_SLOTS];

   logic [COORD_W:0]  ux_ff, uy_ff;
   logic [DIST_W-1:0] sqx_ff, sqy_ff, dist_ff;

   logic [DIST_W-1:0]   sq_val_ff;
   logic [20:0]         sq_rem_ff;
   logic [TRAVEL_W-1:0] sq_root_ff;
   logic [SQRT_CW-1:0]  sq_cnt_ff;

   logic signed [COORD_W-1:0] ax, ay, bx, by;
   logic signed [COORD_W:0]   dx, dy;
   logic [20:0]               rem_sh, trial;

   logic [5:0]                rsp_slot_ff;
   logic [2:0]                rsp_phase_ff;
   logic signed [COORD_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic [TRAVEL_W-1:0]       rsp_travel_ff;
   logic                      rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= MATCH_RESET;
         still_ff    <= STILL_RESET;
         hold_cfg_ff <= HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MATCH: match_ff    <= csr_wdata;
            CSR_STILL: still_ff    <= csr_wdata;
            CSR_HOLD:  hold_cfg_ff <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         pt_x_ff[0] <= req_p0_x;  pt_y_ff[0] <= req_p0_y;
         pt_x_ff[1] <= req_p1_x;  pt_y_ff[1] <= req_p1_y;
         pt_x_ff[2] <= req_p2_x;  pt_y_ff[2] <= req_p2_y;
         pt_x_ff[3] <= req_p3_x;  pt_y_ff[3] <= req_p3_y;
      end
   end

   // Distance unit: absolute differences, then squares, then the sum.
   always_comb begin
      ax = pt_x_ff[cmd.pnt];
      ay = pt_y_ff[cmd.pnt];
      case (cmd.dsel)
         DSEL_WAY: begin
            bx = way_x_ff[cmd.slot];
            by = way_y_ff[cmd.slot];
         end
         DSEL_ORIG: begin
            bx = org_x_ff[cmd.slot];
            by = org_y_ff[cmd.slot];
         end
         default: begin
            bx = pos_x_ff[cmd.slot];
            by = pos_y_ff[cmd.slot];
         end
      endcase
      dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
      dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
   end

   always_ff @(posedge clock) begin
      ux_ff   <= dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
      uy_ff   <= dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
      sqx_ff  <= DIST_W'(ux_ff * ux_ff);
      sqy_ff  <= DIST_W'(uy_ff * uy_ff);
      dist_ff <= sqx_ff + sqy_ff;
   end

   // Square root, two radicand bits per cycle.
   always_comb begin
      rem_sh = {sq_rem_ff[18:0], sq_val_ff[DIST_W-1 -: 2]};
      trial  = {2'b00, sq_root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_cnt_ff <= '0;
      end else if (cmd.op == OP_SQRT_START) begin
         sq_cnt_ff <= SQRT_CW'(SQRT_STEPS);
      end else if (sq_cnt_ff != '0) begin
         sq_cnt_ff <= sq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SQRT_START) begin
         sq_val_ff  <= dist_ff;
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end else if (sq_cnt_ff != '0) begin
         sq_val_ff <= {sq_val_ff[DIST_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            sq_rem_ff  <= rem_sh - trial;
            sq_root_ff <= {sq_root_ff[TRAVEL_W-2:0], 1'b1};
         end else begin
            sq_rem_ff  <= rem_sh;
            sq_root_ff <= {sq_root_ff[TRAVEL_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < TOUCH_SLOTS; s++) begin
            phase_ff[s] <= PH_IDLE;
            pos_x_ff[s] <= '0;  pos_y_ff[s] <= '0;
            org_x_ff[s] <= '0;  org_y_ff[s] <= '0;
            way_x_ff[s] <= '0;  way_y_ff[s] <= '0;
            trav_ff[s]  <= '0;
            hold_ff[s]  <= '0;
         end
      end else begin
         case (cmd.op)
            OP_SET_ENDED: phase_ff[cmd.slot] <= PH_ENDED;
            OP_CLEAR: begin
               phase_ff[cmd.slot] <= PH_IDLE;
               pos_x_ff[cmd.slot] <= '0;  pos_y_ff[cmd.slot] <= '0;
               org_x_ff[cmd.slot] <= '0;  org_y_ff[cmd.slot] <= '0;
               way_x_ff[cmd.slot] <= '0;  way_y_ff[cmd.slot] <= '0;
               trav_ff[cmd.slot]  <= '0;
            end
            OP_CLAIM_POS: begin
               pos_x_ff[cmd.slot] <= pt_x_ff[cmd.pnt];
               pos_y_ff[cmd.slot] <= pt_y_ff[cmd.pnt];
            end
            OP_MOVED_WAY: begin
               phase_ff[cmd.slot] <= PH_MOVED;
               way_x_ff[cmd.slot] <= pt_x_ff[cmd.pnt];
               way_y_ff[cmd.slot] <= pt_y_ff[cmd.pnt];
               hold_ff[cmd.slot]  <= hold_cfg_ff;
            end
            OP_MOVED_HOLD: begin
               phase_ff[cmd.slot] <= PH_MOVED;
               hold_ff[cmd.slot]  <= hold_ff[cmd.slot] - 1'b1;
            end
            OP_STILL: begin
               phase_ff[cmd.slot] <= PH_STILL;
               org_x_ff[cmd.slot] <= pt_x_ff[cmd.pnt];
               org_y_ff[cmd.slot] <= pt_y_ff[cmd.pnt];
            end
            OP_TRAVEL_WR: trav_ff[cmd.slot] <= sq_root_ff;
            OP_BEGIN: begin
               phase_ff[cmd.slot] <= PH_BEGAN;
               pos_x_ff[cmd.slot] <= pt_x_ff[cmd.pnt];
               pos_y_ff[cmd.slot] <= pt_y_ff[cmd.pnt];
               org_x_ff[cmd.slot] <= pt_x_ff[cmd.pnt];
               org_y_ff[cmd.slot] <= pt_y_ff[cmd.pnt];
               way_x_ff[cmd.slot] <= pt_x_ff[cmd.pnt];
               way_y_ff[cmd.slot] <= pt_y_ff[cmd.pnt];
               trav_ff[cmd.slot]  <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_RSP) begin
         rsp_slot_ff   <= 6'(cmd.slot);
         rsp_phase_ff  <= phase_ff[cmd.slot];
         rsp_pos_x_ff  <= pos_x_ff[cmd.slot];
         rsp_pos_y_ff  <= pos_y_ff[cmd.slot];
         rsp_travel_ff <= trav_ff[cmd.slot];
         rsp_last_ff   <= cmd.last;
      end
   end

   always_comb begin
      status.phase     = phase_ff[cmd.slot];
      status.lt_match  = (dist_ff < match_ff);
      status.gt_still  = (dist_ff > still_ff);
      status.hold_nz   = (hold_ff[cmd.slot] != '0);
      status.sqrt_done = (sq_cnt_ff == '0);
      for (int i = 0; i < MAX_POINTS; i++) begin
         status.pt_nz[i] = (pt_x_ff[i] != '0) || (pt_y_ff[i] != '0);
      end
   end

   assign rsp_slot   = rsp_slot_ff;
   assign rsp_phase  = rsp_phase_ff;
   assign rsp_pos_x  = rsp_pos_x_ff;
   assign rsp_pos_y  = rsp_pos_y_ff;
   assign rsp_travel = rsp_travel_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/touch_slot_tracker_unit.sv =====
// Touch slot tracker. The request channel takes one beat per frame: four
// points, where a point at the origin means no point. For every frame the
// response channel returns one beat per touch slot, in slot order, with
// rsp_last set on the beat of the final slot.
// The block works on one frame at a time: req_stall is high from the
// accepting edge until the final response beat has been taken. Once the
// points are captured and the candidate set is set up, each active slot
// compares its position with each candidate in turn, skipping absent
// ones; a claimed point is then compared with the waypoint and, if the
// touch has moved, its travel is recomputed by the shared square-root
// unit (two radicand bits per cycle). Ended slots are cleared and idle
// slots skipped; a second pass over the slots places new touches.
// A stalled response beat holds its payload; the next is loaded only once
// the current one is taken. The three limit registers may be written
// through the csr_ port whenever the block is idle.
// Synchronous reset returns all slots to idle with cleared coordinates and
// reloads the limits with their defaults; the block is ready at once.
`default_nettype none
module touch_slot_tracker_unit
   import tst_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [COORD_W-1:0]  req_p0_x,
   input  wire logic signed [COORD_W-1:0]  req_p0_y,
   input  wire logic signed [COORD_W-1:0]  req_p1_x,
   input  wire logic signed [COORD_W-1:0]  req_p1_y,
   input  wire logic signed [COORD_W-1:0]  req_p2_x,
   input  wire logic signed [COORD_W-1:0]  req_p2_y,
   input  wire logic signed [COORD_W-1:0]  req_p3_x,
   input  wire logic signed [COORD_W-1:0]  req_p3_y,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [5:0]                      rsp_slot,
   output logic [2:0]                      rsp_phase,
   output logic signed [COORD_W-1:0]       rsp_pos_x,
   output logic signed [COORD_W-1:0]       rsp_pos_y,
   output logic [TRAVEL_W-1:0]             rsp_travel,
   output logic                            rsp_last,
   input  wire logic                       csr_we,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [DIST_W-1:0]          csr_wdata
);

   // The controller walks slots and points; the datapath holds the slot
   // table, the distance unit and the square-root unit.
   cmd_type    cmd;
   status_type status;

   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tst_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_p0_x   (req_p0_x),
      .req_p0_y   (req_p0_y),
      .req_p1_x   (req_p1_x),
      .req_p1_y   (req_p1_y),
      .req_p2_x   (req_p2_x),
      .req_p2_y   (req_p2_y),
      .req_p3_x   (req_p3_x),
      .req_p3_y   (req_p3_y),
      .rsp_slot   (rsp_slot),
      .rsp_phase  (rsp_phase),
      .rsp_pos_x  (rsp_pos_x),
      .rsp_pos_y  (rsp_pos_y),
      .rsp_travel (rsp_travel),
      .rsp_last   (rsp_last)
   );

endmodule
`default_nettype wire
